FILE: hdl/wfkmp_pkg.sv
`timescale 1ns / 1ps
package wfkmp_pkg;

	localparam int MAX_PATTERN_DEF = 256;
	localparam int MAX_TEXT_DEF    = 4096;
	localparam int FACTOR_LEN_DEF  = 16;

	localparam int BYTE_W     = 8;
	localparam int HASH_W     = 16;
	localparam int HASH_DEPTH = 65536;
	localparam int COUNT_W    = 13;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

	localparam int ST_W = 6;

	// sequencer states, also the command the datapath executes
	localparam logic [ST_W-1:0] ST_IDLE     = 6'd0;
	localparam logic [ST_W-1:0] ST_FB_INIT  = 6'd1;
	localparam logic [ST_W-1:0] ST_FB_LOOP  = 6'd2;
	localparam logic [ST_W-1:0] ST_FB_PI    = 6'd3;
	localparam logic [ST_W-1:0] ST_FB_INNER = 6'd4;
	localparam logic [ST_W-1:0] ST_FB_PK    = 6'd5;
	localparam logic [ST_W-1:0] ST_FB_FBK   = 6'd6;
	localparam logic [ST_W-1:0] ST_FB_INC   = 6'd7;
	localparam logic [ST_W-1:0] ST_FB_T     = 6'd8;
	localparam logic [ST_W-1:0] ST_FB_T2    = 6'd9;
	localparam logic [ST_W-1:0] ST_FB_T3    = 6'd10;
	localparam logic [ST_W-1:0] ST_FB_T4    = 6'd11;
	localparam logic [ST_W-1:0] ST_BM_CLR   = 6'd12;
	localparam logic [ST_W-1:0] ST_BM_I     = 6'd13;
	localparam logic [ST_W-1:0] ST_BM_RD    = 6'd14;
	localparam logic [ST_W-1:0] ST_BM_WR    = 6'd15;
	localparam logic [ST_W-1:0] ST_CP_RD    = 6'd16;
	localparam logic [ST_W-1:0] ST_CP_WR    = 6'd17;
	localparam logic [ST_W-1:0] ST_S_TOP    = 6'd18;
	localparam logic [ST_W-1:0] ST_S_SKIP   = 6'd19;
	localparam logic [ST_W-1:0] ST_S_SKB    = 6'd20;
	localparam logic [ST_W-1:0] ST_S_SKC    = 6'd21;
	localparam logic [ST_W-1:0] ST_S_LOOP   = 6'd22;
	localparam logic [ST_W-1:0] ST_S_LT     = 6'd23;
	localparam logic [ST_W-1:0] ST_S_LH     = 6'd24;
	localparam logic [ST_W-1:0] ST_S_AFTER  = 6'd25;
	localparam logic [ST_W-1:0] ST_S_V      = 6'd26;
	localparam logic [ST_W-1:0] ST_S_VI     = 6'd27;
	localparam logic [ST_W-1:0] ST_S_VC     = 6'd28;
	localparam logic [ST_W-1:0] ST_S_VM     = 6'd29;
	localparam logic [ST_W-1:0] ST_S_VF     = 6'd30;
	localparam logic [ST_W-1:0] ST_DONE     = 6'd31;

	typedef struct packed {
		logic [ST_W-1:0] code;
		logic            accept;
		logic            load;
	} wfkmp_cmd_t;

	typedef struct packed {
		logic pready;
		logic i_ge_m;
		logic k_ge0;
		logic p_eq_pi;
		logic clr_last;
		logic k_stop;
		logic j_ge_n;
		logic j_ge_lim;
		logic bm_bit;
		logic test;
		logic j_le_b;
		logic st_ge_span;
		logic st_lt_m;
		logic p_eq_t;
	} wfkmp_status_t;

endpackage

FILE: hdl/wfkmp_in_if.sv
`timescale 1ns / 1ps
interface wfkmp_in_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [wfkmp_pkg::BYTE_W-1:0]  byte_value;
	logic                          is_last;

	modport source (output valid, kind, byte_value, is_last, input ready);
	modport sink (input valid, kind, byte_value, is_last, output ready);
endinterface

FILE: hdl/wfkmp_out_if.sv
`timescale 1ns / 1ps
interface wfkmp_out_if;
	logic                          valid;
	logic                          ready;
	logic [wfkmp_pkg::COUNT_W-1:0] match_count;
	logic                          overflow;

	modport source (output valid, match_count, overflow, input ready);
	modport sink (input valid, match_count, overflow, output ready);
endinterface

FILE: hdl/weak_factor_kmp_string_search.sv
`timescale 1ns / 1ps
// Exact string matcher: weak factor window scan with KMP verification.
// in_ch carries one byte per transaction: kind 0 loads the pattern, kind 1 the
// text; is_last closes either one. Bytes are taken at one per cycle while idle.
// Closing the pattern builds the fallback table, clears the 65536-entry
// factor bitmap (one entry a cycle) and then marks factor hashes (at most
// m*min(m,FACTOR_LEN) factors). Input is held off meanwhile.
// Closing the text copies the pattern behind it, then runs the scan, which
// skips windows, reads text bytes backward, verifies bytes and takes fallback
// steps, all paced by the single read port of each memory.
// The result appears on out_ch: match_count and overflow. One result is made
// per text; a text closed before any pattern gives a count of zero.
// The result sits in an output register; input bytes keep flowing while it
// waits, and a following text result waits in the done state until the
// receiver takes the first one.
// Reset empties pattern and text lengths, the overflow flag and the pending
// result; memories are not cleared.
module weak_factor_kmp_string_search #(
	parameter int MAX_PATTERN = wfkmp_pkg::MAX_PATTERN_DEF,
	parameter int MAX_TEXT    = wfkmp_pkg::MAX_TEXT_DEF,
	parameter int FACTOR_LEN  = wfkmp_pkg::FACTOR_LEN_DEF
) (
	input logic         clk,
	input logic         arst_n,
	wfkmp_in_if.sink    in_ch,
	wfkmp_out_if.source out_ch
);
	wfkmp_pkg::wfkmp_cmd_t    cmd;
	wfkmp_pkg::wfkmp_status_t status;

	wfkmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_kind   (in_ch.kind),
		.in_last   (in_ch.is_last),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	wfkmp_dp #(
		.MAX_PATTERN (MAX_PATTERN),
		.MAX_TEXT    (MAX_TEXT),
		.FACTOR_LEN  (FACTOR_LEN)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_kind     (in_ch.kind),
		.in_byte     (in_ch.byte_value),
		.in_last     (in_ch.is_last),
		.match_count (out_ch.match_count),
		.overflow    (out_ch.overflow)
	);
endmodule

FILE: hdl/wfkmp_ram.sv
`timescale 1ns / 1ps
module wfkmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/wfkmp_ctrl.sv
`timescale 1ns / 1ps
module wfkmp_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_kind,
	input  logic                     in_last,
	output logic                     in_ready,
	output logic                     out_valid,
	input  logic                     out_ready,
	input  wfkmp_pkg::wfkmp_status_t status,
	output wfkmp_pkg::wfkmp_cmd_t    cmd
);
	logic [wfkmp_pkg::ST_W-1:0] state_q, state_d;
	logic                       out_valid_q;
	logic                       accept, load;

	assign in_ready  = (state_q == wfkmp_pkg::ST_IDLE);
	assign accept    = in_ready && in_valid;
	assign load      = (state_q == wfkmp_pkg::ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign cmd       = '{code: state_q, accept: accept, load: load};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wfkmp_pkg::ST_IDLE: begin
				if (accept && in_last) begin
					if (!in_kind) state_d = wfkmp_pkg::ST_FB_INIT;
					else if (status.pready) state_d = wfkmp_pkg::ST_CP_RD;
					else state_d = wfkmp_pkg::ST_DONE;
				end
			end
			wfkmp_pkg::ST_FB_INIT:  state_d = wfkmp_pkg::ST_FB_LOOP;
			wfkmp_pkg::ST_FB_LOOP:
				state_d = status.i_ge_m ? wfkmp_pkg::ST_BM_CLR : wfkmp_pkg::ST_FB_PI;
			wfkmp_pkg::ST_FB_PI:    state_d = wfkmp_pkg::ST_FB_INNER;
			wfkmp_pkg::ST_FB_INNER:
				state_d = status.k_ge0 ? wfkmp_pkg::ST_FB_PK : wfkmp_pkg::ST_FB_INC;
			wfkmp_pkg::ST_FB_PK:
				state_d = status.p_eq_pi ? wfkmp_pkg::ST_FB_INC : wfkmp_pkg::ST_FB_FBK;
			wfkmp_pkg::ST_FB_FBK:   state_d = wfkmp_pkg::ST_FB_INNER;
			wfkmp_pkg::ST_FB_INC:   state_d = wfkmp_pkg::ST_FB_T;
			wfkmp_pkg::ST_FB_T:
				state_d = status.i_ge_m ? wfkmp_pkg::ST_FB_LOOP : wfkmp_pkg::ST_FB_T2;
			wfkmp_pkg::ST_FB_T2:    state_d = wfkmp_pkg::ST_FB_T3;
			wfkmp_pkg::ST_FB_T3:
				state_d = status.p_eq_pi ? wfkmp_pkg::ST_FB_T4 : wfkmp_pkg::ST_FB_LOOP;
			wfkmp_pkg::ST_FB_T4:    state_d = wfkmp_pkg::ST_FB_LOOP;
			wfkmp_pkg::ST_BM_CLR:
				state_d = status.clr_last ? wfkmp_pkg::ST_BM_I : wfkmp_pkg::ST_BM_CLR;
			wfkmp_pkg::ST_BM_I:
				state_d = status.i_ge_m ? wfkmp_pkg::ST_IDLE : wfkmp_pkg::ST_BM_RD;
			wfkmp_pkg::ST_BM_RD:    state_d = wfkmp_pkg::ST_BM_WR;
			wfkmp_pkg::ST_BM_WR:
				state_d = status.k_stop ? wfkmp_pkg::ST_BM_I : wfkmp_pkg::ST_BM_RD;
			wfkmp_pkg::ST_CP_RD:
				state_d = status.i_ge_m ? wfkmp_pkg::ST_S_TOP : wfkmp_pkg::ST_CP_WR;
			wfkmp_pkg::ST_CP_WR:    state_d = wfkmp_pkg::ST_CP_RD;
			wfkmp_pkg::ST_S_TOP:
				state_d = status.j_ge_n ? wfkmp_pkg::ST_DONE : wfkmp_pkg::ST_S_SKIP;
			wfkmp_pkg::ST_S_SKIP:
				state_d = status.j_ge_lim ? wfkmp_pkg::ST_DONE : wfkmp_pkg::ST_S_SKB;
			wfkmp_pkg::ST_S_SKB:    state_d = wfkmp_pkg::ST_S_SKC;
			wfkmp_pkg::ST_S_SKC:
				state_d = status.bm_bit ? wfkmp_pkg::ST_S_LOOP : wfkmp_pkg::ST_S_SKIP;
			wfkmp_pkg::ST_S_LOOP:   state_d = wfkmp_pkg::ST_S_LT;
			wfkmp_pkg::ST_S_LT:
				state_d = (!status.bm_bit || status.j_le_b) ? wfkmp_pkg::ST_S_AFTER
				                                            : wfkmp_pkg::ST_S_LH;
			wfkmp_pkg::ST_S_LH:     state_d = wfkmp_pkg::ST_S_LOOP;
			wfkmp_pkg::ST_S_AFTER:
				state_d = (status.j_le_b && status.test) ? wfkmp_pkg::ST_S_V
				                                         : wfkmp_pkg::ST_S_TOP;
			wfkmp_pkg::ST_S_V:
				state_d = status.st_ge_span ? wfkmp_pkg::ST_S_VI : wfkmp_pkg::ST_S_TOP;
			wfkmp_pkg::ST_S_VI:
				state_d = status.st_lt_m ? wfkmp_pkg::ST_S_VC : wfkmp_pkg::ST_S_VM;
			wfkmp_pkg::ST_S_VC:
				state_d = status.p_eq_t ? wfkmp_pkg::ST_S_VI : wfkmp_pkg::ST_S_VM;
			wfkmp_pkg::ST_S_VM:     state_d = wfkmp_pkg::ST_S_VF;
			wfkmp_pkg::ST_S_VF:     state_d = wfkmp_pkg::ST_S_V;
			wfkmp_pkg::ST_DONE:
				state_d = load ? wfkmp_pkg::ST_IDLE : wfkmp_pkg::ST_DONE;
			default:                state_d = wfkmp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wfkmp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == wfkmp_pkg::ST_DONE)
		else $error("result raised outside the done state");
	a_held_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wfkmp_pkg::ST_DONE && out_valid_q && !out_ready)
		|=> state_q == wfkmp_pkg::ST_DONE)
		else $error("done state left while a result was still pending");
	a_no_input_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != wfkmp_pkg::ST_IDLE) |-> !accept)
		else $error("transaction accepted during processing");
endmodule

FILE: hdl/wfkmp_dp.sv
`timescale 1ns / 1ps
module wfkmp_dp #(
	parameter int MAX_PATTERN = wfkmp_pkg::MAX_PATTERN_DEF,
	parameter int MAX_TEXT    = wfkmp_pkg::MAX_TEXT_DEF,
	parameter int FACTOR_LEN  = wfkmp_pkg::FACTOR_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wfkmp_pkg::wfkmp_cmd_t         cmd,
	output wfkmp_pkg::wfkmp_status_t      status,
	input  logic                          in_kind,
	input  logic [wfkmp_pkg::BYTE_W-1:0]  in_byte,
	input  logic                          in_last,
	output logic [wfkmp_pkg::COUNT_W-1:0] match_count,
	output logic                          overflow
);
	localparam int TEXT_CAP = MAX_TEXT + MAX_PATTERN;
	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int TW = $clog2(MAX_TEXT + 1);
	localparam int SW = LW + 1;
	localparam int PW = $clog2(TEXT_CAP + 1) + 2;
	localparam int PA = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int FA = $clog2(MAX_PATTERN + 1);
	localparam int TA = $clog2(TEXT_CAP);
	localparam int DW = (FACTOR_LEN > 1) ? $clog2(FACTOR_LEN) : 1;
	localparam int HW = wfkmp_pkg::HASH_W;
	localparam int BW = wfkmp_pkg::BYTE_W;
	localparam int CW = wfkmp_pkg::COUNT_W;

	// control state
	logic [LW-1:0] plen_q;
	logic [TW-1:0] tlen_q;
	logic          ovf_q, pready_q;

	// work registers
	logic [LW-1:0]        i_q;
	logic signed [SW-1:0] k_q, st_q;
	logic [DW-1:0]        d_q;
	logic [HW-1:0]        h_q, clr_q;
	logic [BW-1:0]        pi_q, tx_q;
	logic signed [PW-1:0] j_q, tp_q, lf_q, b_q;
	logic                 test_q, tv_q;
	logic [CW-1:0]        count_q;

	// memory ports
	logic          p_we, t_we, f_we, b_we;
	logic [PA-1:0] p_waddr, p_raddr;
	logic [TA-1:0] t_waddr, t_raddr;
	logic [FA-1:0] f_waddr, f_raddr;
	logic [HW-1:0] b_waddr, b_raddr;
	logic [BW-1:0] p_wdata, t_wdata, rd_p, rd_t;
	logic [SW-1:0] f_wdata, rd_f;
	logic          b_wdata, rd_b;

	logic [LW-1:0]        len_eff;
	logic                 p_room, t_room, acc_p, acc_t;
	logic signed [PW-1:0] m_s, n_s, st_ext, t_pos, lf_c, tpm1, b_c;
	logic                 t_inrange;
	logic [BW-1:0]        txv;
	logic [HW-1:0]        hn;
	logic [DW-1:0]        factm1;

	assign len_eff = pready_q ? '0 : plen_q;
	assign p_room  = 32'(len_eff) < 32'(MAX_PATTERN);
	assign t_room  = 32'(tlen_q) < 32'(MAX_TEXT);
	assign acc_p   = cmd.accept && !in_kind;
	assign acc_t   = cmd.accept && in_kind;

	assign m_s    = $signed(PW'(plen_q));
	assign n_s    = $signed(PW'(tlen_q));
	assign st_ext = PW'(st_q);
	assign txv    = tv_q ? rd_t : '0;
	assign hn     = {h_q[HW-3:0], 2'b00} + HW'(rd_p);
	assign lf_c   = j_q - m_s + PW'(1);
	assign tpm1   = tp_q - PW'(1);
	assign b_c    = (tpm1 < lf_c) ? lf_c : tpm1;
	assign factm1 = (32'(plen_q) >= 32'(FACTOR_LEN)) ? DW'(FACTOR_LEN - 1)
	                                                 : DW'(plen_q - 1'b1);

	always_comb begin
		unique case (cmd.code)
			wfkmp_pkg::ST_S_LT: t_pos = j_q - PW'(1);
			wfkmp_pkg::ST_S_VI: t_pos = tp_q;
			default:            t_pos = j_q;
		endcase
	end
	assign t_inrange = (t_pos >= 0) && (t_pos < $signed(PW'(TEXT_CAP)));

	always_comb begin
		p_we    = acc_p && p_room;
		p_waddr = PA'(len_eff);
		p_wdata = in_byte;
		unique case (cmd.code)
			wfkmp_pkg::ST_FB_INNER, wfkmp_pkg::ST_FB_T2, wfkmp_pkg::ST_BM_RD:
				p_raddr = PA'(k_q);
			wfkmp_pkg::ST_S_VI:
				p_raddr = PA'(st_q);
			default:
				p_raddr = PA'(i_q);
		endcase

		t_we    = 1'b0;
		t_waddr = TA'(tlen_q);
		t_wdata = in_byte;
		if (acc_t && t_room) begin
			t_we = 1'b1;
		end else if (cmd.code == wfkmp_pkg::ST_CP_WR) begin
			t_we    = 1'b1;
			t_waddr = TA'(tlen_q) + TA'(i_q);
			t_wdata = rd_p;
		end
		t_raddr = t_pos[TA-1:0];

		f_we    = 1'b0;
		f_waddr = FA'(i_q);
		f_wdata = SW'(k_q);
		unique case (cmd.code)
			wfkmp_pkg::ST_FB_INIT: begin
				f_we    = 1'b1;
				f_waddr = '0;
				f_wdata = '1;
			end
			wfkmp_pkg::ST_FB_T:  f_we = status.i_ge_m;
			wfkmp_pkg::ST_FB_T3: f_we = (rd_p != pi_q);
			wfkmp_pkg::ST_FB_T4: begin
				f_we    = 1'b1;
				f_wdata = rd_f;
			end
			default: ;
		endcase
		f_raddr = (cmd.code == wfkmp_pkg::ST_S_VM) ? FA'(st_q) : FA'(k_q);

		b_we    = 1'b0;
		b_waddr = clr_q;
		b_wdata = 1'b0;
		if (cmd.code == wfkmp_pkg::ST_BM_CLR) begin
			b_we = 1'b1;
		end else if (cmd.code == wfkmp_pkg::ST_BM_WR) begin
			b_we    = 1'b1;
			b_waddr = hn;
			b_wdata = 1'b1;
		end
		b_raddr = (cmd.code == wfkmp_pkg::ST_S_SKB) ? HW'(txv) : h_q;
	end

	wfkmp_ram #(.WIDTH(BW), .DEPTH(MAX_PATTERN)) u_pattern (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(rd_p)
	);
	wfkmp_ram #(.WIDTH(BW), .DEPTH(TEXT_CAP)) u_text (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(rd_t)
	);
	wfkmp_ram #(.WIDTH(SW), .DEPTH(MAX_PATTERN + 1)) u_fallback (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(rd_f)
	);
	wfkmp_ram #(.WIDTH(1), .DEPTH(wfkmp_pkg::HASH_DEPTH)) u_bitmap (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(b_raddr), .rdata(rd_b)
	);

	always_comb begin
		status.pready     = pready_q;
		status.i_ge_m     = i_q >= plen_q;
		status.k_ge0      = !k_q[SW-1];
		status.p_eq_pi    = rd_p == pi_q;
		status.clr_last   = &clr_q;
		status.k_stop     = (k_q == '0) || (d_q == factm1);
		status.j_ge_n     = j_q >= n_s;
		status.j_ge_lim   = j_q >= (n_s + m_s);
		status.bm_bit     = rd_b;
		status.test       = test_q;
		status.j_le_b     = j_q <= b_q;
		status.st_ge_span = st_ext >= (tp_q - lf_q);
		status.st_lt_m    = st_ext < m_s;
		status.p_eq_t     = rd_p == txv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q   <= '0;
			tlen_q   <= '0;
			ovf_q    <= 1'b0;
			pready_q <= 1'b0;
		end else begin
			if (acc_p) begin
				pready_q <= 1'b0;
				plen_q   <= p_room ? len_eff + 1'b1 : len_eff;
				if (!p_room) ovf_q <= 1'b1;
			end
			if (acc_t) begin
				if (t_room) tlen_q <= tlen_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (cmd.code == wfkmp_pkg::ST_BM_I && status.i_ge_m) pready_q <= 1'b1;
			if (cmd.load) begin
				tlen_q <= '0;
				ovf_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tv_q <= t_inrange;
		if (cmd.load) begin
			match_count <= count_q;
			overflow    <= ovf_q;
		end
		if (acc_t && in_last) begin
			count_q <= '0;
			i_q     <= '0;
			tp_q    <= '0;
			st_q    <= '0;
			j_q     <= m_s - PW'(1);
		end
		unique case (cmd.code)
			wfkmp_pkg::ST_FB_INIT: begin
				i_q   <= '0;
				k_q   <= '1;
				clr_q <= '0;
			end
			wfkmp_pkg::ST_FB_PI, wfkmp_pkg::ST_FB_T2: pi_q <= rd_p;
			wfkmp_pkg::ST_FB_FBK: k_q <= $signed(rd_f);
			wfkmp_pkg::ST_FB_INC: begin
				i_q <= i_q + 1'b1;
				k_q <= k_q + SW'(1);
			end
			wfkmp_pkg::ST_BM_CLR: begin
				clr_q <= clr_q + 1'b1;
				if (&clr_q) i_q <= '0;
			end
			wfkmp_pkg::ST_BM_I: begin
				k_q <= $signed(SW'(i_q));
				h_q <= '0;
				d_q <= '0;
			end
			wfkmp_pkg::ST_BM_WR: begin
				h_q <= hn;
				if (status.k_stop) begin
					i_q <= i_q + 1'b1;
				end else begin
					k_q <= k_q - SW'(1);
					d_q <= d_q + 1'b1;
				end
			end
			wfkmp_pkg::ST_CP_WR: i_q <= i_q + 1'b1;
			wfkmp_pkg::ST_S_SKB: tx_q <= txv;
			wfkmp_pkg::ST_S_SKC: begin
				if (rd_b) begin
					lf_q <= lf_c;
					b_q  <= b_c;
					h_q  <= HW'(tx_q);
				end else begin
					j_q <= j_q + m_s;
				end
			end
			wfkmp_pkg::ST_S_LT: begin
				test_q <= rd_b;
				if (rd_b && !status.j_le_b) j_q <= j_q - PW'(1);
			end
			wfkmp_pkg::ST_S_LH: h_q <= {h_q[HW-3:0], 2'b00} + HW'(txv);
			wfkmp_pkg::ST_S_AFTER: begin
				if (status.j_le_b && test_q) begin
					if (lf_q > tp_q) begin
						tp_q <= lf_q;
						st_q <= '0;
					end
				end else begin
					j_q <= j_q + m_s;
				end
			end
			wfkmp_pkg::ST_S_V:
				if (!status.st_ge_span) j_q <= tp_q + m_s - PW'(1) - st_ext;
			wfkmp_pkg::ST_S_VC:
				if (status.p_eq_t) begin
					st_q <= st_q + SW'(1);
					tp_q <= tp_q + PW'(1);
				end
			wfkmp_pkg::ST_S_VM:
				if (st_ext == m_s && (lf_q + m_s) <= n_s && count_q < wfkmp_pkg::COUNT_MAX)
					count_q <= count_q + 1'b1;
			wfkmp_pkg::ST_S_VF: begin
				if (rd_f[SW-1]) begin
					st_q <= '0;
					tp_q <= tp_q + PW'(1);
				end else begin
					st_q <= $signed(rd_f);
				end
			end
			default: ;
		endcase
	end

	a_pready_len: assert property (@(posedge clk) disable iff (!arst_n)
		pready_q |-> plen_q != '0)
		else $error("pattern marked complete with zero length");
	a_st_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.code == wfkmp_pkg::ST_S_VI) |-> (st_ext <= m_s && !st_q[SW-1]))
		else $error("verifier state outside the pattern");
	a_factor_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.code == wfkmp_pkg::ST_BM_WR) |-> (d_q <= factm1))
		else $error("factor hash longer than the factor limit");
endmodule
